/* design/lbp_pkg.sv */
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants and types of the multi-block LBP code extractor.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int BLOCK_SIZE = 2;
    localparam int BLK_SHIFT  = $clog2(BLOCK_SIZE);

    localparam int PIX_W      = 8;
    localparam int PAIR_W     = 9;
    localparam int ROW_W      = 12;
    localparam int IWID_W     = 11;
    localparam int HGT_W      = 13;
    localparam int BROW_W     = 11;
    localparam int BCOL_W     = 9;
    localparam int CODE_W     = 8;
    localparam int EXT_W      = 14;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam int MIN_SIZE     = 8;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // per-pixel decode carried into the compute stage
    typedef struct packed {
        logic              pair_first;  // left pixel of a pair
        logic              pair_top;    // right pixel, upper row of a block
        logic              block_done;  // right pixel, lower row of a block
        logic              slot;        // block-row parity, selects line slot
        logic              emit;        // block completes a code in the grid
        logic              last;        // last code of the frame
        logic [BROW_W-1:0] block_row;
        logic [BCOL_W-1:0] block_col;
    } lbp_tag_t;

endpackage

/* design/lbp_front.sv */
// ----------------------------------------------------------------------------
// lbp_front
// Config registers, raster position tracking, pixel decode, line-store read
// issue and the compute-stage input register.
// ----------------------------------------------------------------------------
module lbp_front #(
    parameter int BORDER    = 4,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lbp_pkg::PIX_W-1:0]      in_pixel,
    input  logic                           in_frame_start,
    input  logic                           s1_fire,
    output logic                           mode,
    output logic                           s1_valid,
    output logic [lbp_pkg::PIX_W-1:0]      s1_pixel,
    output lbp_pkg::lbp_tag_t              s1_tag,
    output logic [$clog2((MAX_WIDTH+1)/2)-1:0] s1_addr,
    output logic                           rd_en,
    output logic [$clog2((MAX_WIDTH+1)/2)-1:0] rd_addr
);
    import lbp_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int AW    = $clog2((MAX_WIDTH+1)/2);
    localparam int PAR   = BORDER % 2;
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic              mode_reg;
    logic [WW-1:0]     width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;

    logic              s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]  s1_pixel_reg;
    lbp_tag_t          s1_tag_reg;
    logic [AW-1:0]     s1_addr_reg;

    logic [EXT_W-1:0]  width_sel, height_sel, wx, hx;
    logic              accept;
    logic [ROW_W-1:0]  cur_row;
    logic [CW-1:0]     cur_col;
    logic [EXT_W-1:0]  r_x, c_x, rp_x, cp_x, rb_x, cb_x, w_x, h_x, col_inc, row_inc;
    logic              in_grid, in_window;
    lbp_tag_t          tag;

    // ---- configuration, clamped when written
    always_comb
    begin
        wx = EXT_W'(cfg_data[IWID_W-1:0]);
        hx = EXT_W'(cfg_data);
        if (wx < EXT_W'(MIN_SIZE))
            width_sel = EXT_W'(MIN_SIZE);
        else if (wx > EXT_W'(MAX_WIDTH))
            width_sel = EXT_W'(MAX_WIDTH);
        else
            width_sel = wx;
        if (hx < EXT_W'(MIN_SIZE))
            height_sel = EXT_W'(MIN_SIZE);
        else if (hx > EXT_W'(MAX_HEIGHT))
            height_sel = EXT_W'(MAX_HEIGHT);
        else
            height_sel = hx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= WW'(W_RST);
            height_reg <= HGT_W'(HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_WIDTH:  width_reg  <= WW'(width_sel);
                CFG_HEIGHT: height_reg <= HGT_W'(height_sel);
                default:    ;
            endcase
        end
    end

    // ---- position of the incoming pixel
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;
    assign cur_row  = in_frame_start ? '0 : row_reg;
    assign cur_col  = in_frame_start ? '0 : col_reg;

    always_comb
    begin
        r_x     = EXT_W'(cur_row);
        c_x     = EXT_W'(cur_col);
        w_x     = EXT_W'(width_reg);
        h_x     = EXT_W'(height_reg);
        col_inc = c_x + EXT_W'(1);
        row_inc = r_x + EXT_W'(1);
        if (col_inc >= w_x)
        begin
            col_next = '0;
            row_next = (row_inc >= h_x) ? '0 : ROW_W'(row_inc);
        end
        else
        begin
            col_next = CW'(col_inc);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---- decode: pair/block phase and code window bounds
    always_comb
    begin
        rp_x      = r_x - EXT_W'(PAR);
        cp_x      = c_x - EXT_W'(PAR);
        rb_x      = r_x - EXT_W'(BORDER + 3);
        cb_x      = c_x - EXT_W'(BORDER + 3);
        in_grid   = (r_x >= EXT_W'(PAR)) && (c_x >= EXT_W'(PAR));
        in_window = (r_x >= EXT_W'(BORDER + 3)) && (r_x + EXT_W'(BORDER) < h_x + EXT_W'(3))
                 && (c_x >= EXT_W'(BORDER + 3)) && (c_x + EXT_W'(BORDER) < w_x + EXT_W'(3));

        tag.pair_first = in_grid && !cp_x[0];
        tag.pair_top   = in_grid && cp_x[0] && !rp_x[0];
        tag.block_done = in_grid && cp_x[0] && rp_x[0];
        tag.slot       = rp_x[BLK_SHIFT];
        tag.emit       = tag.block_done && in_window;
        tag.last       = (r_x + EXT_W'(BORDER) >= h_x + EXT_W'(1))
                      && (c_x + EXT_W'(BORDER) >= w_x + EXT_W'(1));
        tag.block_row  = rb_x[BROW_W+BLK_SHIFT-1:BLK_SHIFT];
        tag.block_col  = cb_x[BCOL_W+BLK_SHIFT-1:BLK_SHIFT];
    end

    // reads go out with the accept so the data lines up with the stage register
    assign rd_en   = accept;
    assign rd_addr = cp_x[AW+BLK_SHIFT-1:BLK_SHIFT];

    // ---- compute-stage input register
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= in_pixel;
            s1_tag_reg   <= tag;
            s1_addr_reg  <= rd_addr;
        end
    end

    assign mode     = mode_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_pixel = s1_pixel_reg;
    assign s1_tag   = s1_tag_reg;
    assign s1_addr  = s1_addr_reg;

endmodule

/* design/lbp_line_store.sv */
// ----------------------------------------------------------------------------
// lbp_line_store
// Two line memories, one entry per block column: the reduced upper pixel
// pair, and the two latest block rows packed side by side. Registered read.
// ----------------------------------------------------------------------------
module lbp_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [$clog2((MAX_WIDTH+1)/2)-1:0]  rd_addr,
    input  logic [$clog2((MAX_WIDTH+1)/2)-1:0]  wr_addr,
    input  logic                                pair_we,
    input  logic [lbp_pkg::PAIR_W-1:0]          pair_wdata,
    input  logic                                blk_we,
    input  logic [2*lbp_pkg::PIX_W-1:0]         blk_wdata,
    output logic [lbp_pkg::PAIR_W-1:0]          pair_rdata,
    output logic [2*lbp_pkg::PIX_W-1:0]         blk_rdata
);
    import lbp_pkg::*;

    localparam int DEPTH = (MAX_WIDTH + 1) / 2;

    logic [PAIR_W-1:0]  pair_mem [DEPTH];
    logic [2*PIX_W-1:0] blk_mem  [DEPTH];
    logic [PAIR_W-1:0]  pair_rdata_reg;
    logic [2*PIX_W-1:0] blk_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (pair_we)
            pair_mem[wr_addr] <= pair_wdata;
        if (rd_en)
            pair_rdata_reg <= pair_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
            blk_mem[wr_addr] <= blk_wdata;
        if (rd_en)
            blk_rdata_reg <= blk_mem[rd_addr];
    end

    assign pair_rdata = pair_rdata_reg;
    assign blk_rdata  = blk_rdata_reg;

endmodule

/* design/lbp_core.sv */
// ----------------------------------------------------------------------------
// lbp_core
// Compute stage: pair and block reduction, line-store write-back, 3x3 block
// window, neighbor compare and the output word register.
// ----------------------------------------------------------------------------
module lbp_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mode,
    input  logic                        s1_valid,
    input  logic [lbp_pkg::PIX_W-1:0]   s1_pixel,
    input  lbp_pkg::lbp_tag_t           s1_tag,
    output logic                        s1_fire,
    input  logic [lbp_pkg::PAIR_W-1:0]  pair_rdata,
    input  logic [2*lbp_pkg::PIX_W-1:0] blk_rdata,
    output logic                        pair_we,
    output logic [lbp_pkg::PAIR_W-1:0]  pair_wdata,
    output logic                        blk_we,
    output logic [2*lbp_pkg::PIX_W-1:0] blk_wdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lbp_pkg::CODE_W-1:0]  out_code,
    output logic [lbp_pkg::BROW_W-1:0]  out_row,
    output logic [lbp_pkg::BCOL_W-1:0]  out_col,
    output logic                        out_last
);
    import lbp_pkg::*;

    logic [PIX_W-1:0]   left_reg;
    logic [PIX_W-1:0]   win_reg [3][3];

    logic               out_valid_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [BROW_W-1:0]  row_reg;
    logic [BCOL_W-1:0]  col_reg;
    logic               last_reg;

    logic [PAIR_W-1:0]  pair_val, blk_max;
    logic [PAIR_W:0]    blk_sum;
    logic [PIX_W-1:0]   bv, two_up, one_up, ctr;
    logic [CODE_W-1:0]  code;
    logic               blk_upd;

    assign s1_fire = s1_valid && (!out_valid_reg || out_ready);
    assign blk_upd = s1_fire && s1_tag.block_done;

    always_comb
    begin
        if (mode)
            pair_val = (left_reg > s1_pixel) ? PAIR_W'(left_reg) : PAIR_W'(s1_pixel);
        else
            pair_val = PAIR_W'(left_reg) + PAIR_W'(s1_pixel);

        // a stored pair may be a sum from average mode, hence the clip
        blk_max = (pair_rdata > pair_val) ? pair_rdata : pair_val;
        blk_sum = (PAIR_W+1)'(pair_rdata) + (PAIR_W+1)'(pair_val);
        if (mode)
            bv = (blk_max > PAIR_W'(PIX_MAX)) ? PIX_MAX : blk_max[PIX_W-1:0];
        else
            bv = blk_sum[PAIR_W:2];

        two_up = s1_tag.slot ? blk_rdata[2*PIX_W-1:PIX_W] : blk_rdata[PIX_W-1:0];
        one_up = s1_tag.slot ? blk_rdata[PIX_W-1:0] : blk_rdata[2*PIX_W-1:PIX_W];

        // window after this shift; center is the old right column middle
        ctr     = win_reg[1][2];
        code[7] = win_reg[0][1] > ctr;
        code[6] = win_reg[0][2] > ctr;
        code[5] = two_up > ctr;
        code[4] = one_up > ctr;
        code[3] = bv > ctr;
        code[2] = win_reg[2][2] > ctr;
        code[1] = win_reg[2][1] > ctr;
        code[0] = win_reg[1][1] > ctr;
    end

    assign pair_we    = s1_fire && s1_tag.pair_top;
    assign pair_wdata = pair_val;
    assign blk_we     = blk_upd;
    assign blk_wdata  = s1_tag.slot ? {bv, blk_rdata[PIX_W-1:0]}
                                    : {blk_rdata[2*PIX_W-1:PIX_W], bv};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (s1_fire && s1_tag.pair_first)
            left_reg <= s1_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (blk_upd)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= two_up;
            win_reg[1][2] <= one_up;
            win_reg[2][2] <= bv;
        end
    end

    // ---- output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= s1_tag.emit;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_tag.emit)
        begin
            code_reg <= code;
            row_reg  <= s1_tag.block_row;
            col_reg  <= s1_tag.block_col;
            last_reg <= s1_tag.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = code_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_last  = last_reg;

endmodule

/* design/block_lbp_code_extractor.sv */
// ----------------------------------------------------------------------------
// block_lbp_code_extractor
// Multi-block LBP code extractor: 2x2 block reduction (average or max) and
// an 8-bit neighbor code per block inside the border.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata: pixel; tuser: frame_start
//   m_axis    out  tvalid/tready         tdata: code, block_row, block_col;
//                                        tlast: frame_last
//   cfg       in   cfg_we (no wait)      cfg_index, cfg_data
//
// One pixel per cycle sustained while m_axis takes words; a code word is
// registered when the compute stage takes the pixel that completes its
// lower-right neighbor block. Line stores are read on accept and written
// back by the compute stage as it takes the pixel. Reset clears counters,
// window and handshake state; line memories are not cleared. s_axis_tready
// drops only while a word waits on m_axis and the compute stage is full.
// ----------------------------------------------------------------------------
module block_lbp_code_extractor #(
    parameter int BORDER    = 4,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
    input  logic                           s_axis_tuser,   // [0] frame_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [7:0] code,
                                                           // [18:8] block_row,
                                                           // [27:19] block_col
    output logic                           m_axis_tlast    // frame_last
);
    import lbp_pkg::*;

    localparam int AW = $clog2((MAX_WIDTH+1)/2);

    logic                mode;
    logic                s1_valid, s1_fire, rd_en;
    logic [PIX_W-1:0]    s1_pixel;
    lbp_tag_t            s1_tag;
    logic [AW-1:0]       s1_addr, rd_addr;
    logic                pair_we, blk_we;
    logic [PAIR_W-1:0]   pair_wdata, pair_rdata;
    logic [2*PIX_W-1:0]  blk_wdata, blk_rdata;
    logic [CODE_W-1:0]   code;
    logic [BROW_W-1:0]   block_row;
    logic [BCOL_W-1:0]   block_col;

    lbp_front #(
        .BORDER    (BORDER),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_pixel       (s_axis_tdata),
        .in_frame_start (s_axis_tuser),
        .s1_fire        (s1_fire),
        .mode           (mode),
        .s1_valid       (s1_valid),
        .s1_pixel       (s1_pixel),
        .s1_tag         (s1_tag),
        .s1_addr        (s1_addr),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr)
    );

    lbp_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .clk        (clk),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .wr_addr    (s1_addr),
        .pair_we    (pair_we),
        .pair_wdata (pair_wdata),
        .blk_we     (blk_we),
        .blk_wdata  (blk_wdata),
        .pair_rdata (pair_rdata),
        .blk_rdata  (blk_rdata)
    );

    lbp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .s1_valid   (s1_valid),
        .s1_pixel   (s1_pixel),
        .s1_tag     (s1_tag),
        .s1_fire    (s1_fire),
        .pair_rdata (pair_rdata),
        .blk_rdata  (blk_rdata),
        .pair_we    (pair_we),
        .pair_wdata (pair_wdata),
        .blk_we     (blk_we),
        .blk_wdata  (blk_wdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_code   (code),
        .out_row    (block_row),
        .out_col    (block_col),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, block_col, block_row, code};

endmodule

/* design/lbp_checker.sv */
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the LBP code extractor, bound to the top level.
// ----------------------------------------------------------------------------
module lbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // input backpressure only when the output side is stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output not blocked");

    // a fresh word after an idle output comes from an accepted input pixel
    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output word without matching input pixel");

    // pad bits of the output word stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:28] == 4'b0)
        else $error("output pad bits set");

endmodule

bind block_lbp_code_extractor lbp_checker u_lbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* bench/block_lbp_code_extractor_tb.sv */
// ----------------------------------------------------------------------------
// block_lbp_code_extractor_tb
// Self-checking bench for the multi-block LBP code extractor. Pixel words
// stream in on s_axis under random idle bursts and output back-pressure. A
// behavioral model of the block predicts every code word, and each word
// leaving m_axis is compared field by field against the oldest prediction.
// Covers reset defaults, minimum and clamped frame sizes, mode switches
// inside a frame, counter wrap, truncated and noisy frames, long output holds
// and a stretch of random frames.
// ----------------------------------------------------------------------------
module block_lbp_code_extractor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    localparam int BORDER       = 4;
    localparam int MAX_WIDTH    = 1024;
    localparam int HALF_W       = (MAX_WIDTH + 1) / 2;
    localparam int PAR          = BORDER % 2;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 200;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BROW_W-1:0] brow;
        logic [BCOL_W-1:0] bcol;
        logic              is_last;
    } code_word_t;

    typedef enum int {PIX_ANY, PIX_NEAR, PIX_EXTREME, PIX_BRIGHT, PIX_FLAT} pix_kind_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    block_lbp_code_extractor #(
        .BORDER    (BORDER),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // behavioral copy of the block
    // ------------------------------------------------------------------
    logic              mode_reg   = 1'b0;
    logic [IWID_W-1:0] width_reg  = IWID_W'(WIDTH_RESET);
    logic [HGT_W-1:0]  height_reg = HGT_W'(HEIGHT_RESET);

    logic [PAIR_W-1:0] pair_row [HALF_W];
    logic [PIX_W-1:0]  blk_rows [2][HALF_W];
    logic [PIX_W-1:0]  win      [3][3];
    int unsigned       row_cnt  = 0;
    int unsigned       col_cnt  = 0;
    int unsigned       left_pix = 0;

    code_word_t code_expect_q[$];

    int unsigned pixels_sent    = 0;
    int unsigned frames_started = 0;
    int unsigned codes_checked  = 0;
    int unsigned mode_switches  = 0;
    int unsigned fail_count     = 0;

    bit          src_idle_en   = 1'b1;
    bit          sink_stall_en = 1'b1;
    int unsigned hold_len      = 0;
    int unsigned hold_req      = 0;
    logic [7:0]  pix_base      = '0;

    initial
    begin
        for (int i = 0; i < HALF_W; i++)
        begin
            pair_row[i]    = '0;
            blk_rows[0][i] = '0;
            blk_rows[1][i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
    end

    function automatic int unsigned eff_width();
        if (width_reg < MIN_SIZE)
            return MIN_SIZE;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < MIN_SIZE)
            return MIN_SIZE;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_reg;
    endfunction

    task automatic lbp_predict(input logic [7:0] pix, input logic fs);
        int unsigned w, h, r, c, hc, bc, hr, br, pr, top, bv, slot;
        logic [7:0]  two_up, one_up, ctr;
        code_word_t  e;
        w = eff_width();
        h = eff_height();
        if (fs)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt;
        if (r >= PAR && c >= PAR)
        begin
            hc = (c - PAR) % BLOCK_SIZE;
            bc = (c - PAR) / BLOCK_SIZE;
            hr = (r - PAR) % BLOCK_SIZE;
            br = (r - PAR) / BLOCK_SIZE;
            if (bc < HALF_W)
            begin
                if (hc == 0)
                    left_pix = pix;
                else
                begin
                    pr = mode_reg ? ((left_pix > pix) ? left_pix : pix) : left_pix + pix;
                    if (hr == 0)
                        pair_row[bc] = pr[PAIR_W-1:0];
                    else
                    begin
                        top = pair_row[bc];
                        // a sum stored in average mode can exceed 8 bits
                        if (mode_reg)
                        begin
                            bv = (top > pr) ? top : pr;
                            if (bv > 255)
                                bv = 255;
                        end
                        else
                            bv = (top + pr) >> 2;
                        slot   = br & 1;
                        two_up = blk_rows[slot][bc];
                        one_up = blk_rows[slot ^ 1][bc];
                        blk_rows[slot][bc] = bv[7:0];
                        for (int i = 0; i < 3; i++)
                        begin
                            win[i][0] = win[i][1];
                            win[i][1] = win[i][2];
                        end
                        win[0][2] = two_up;
                        win[1][2] = one_up;
                        win[2][2] = bv[7:0];
                        if (r >= BORDER + 3 && r + BORDER < h + 3 &&
                            c >= BORDER + 3 && c + BORDER < w + 3)
                        begin
                            ctr       = win[1][1];
                            e.code[7] = win[0][0] > ctr;
                            e.code[6] = win[0][1] > ctr;
                            e.code[5] = win[0][2] > ctr;
                            e.code[4] = win[1][2] > ctr;
                            e.code[3] = win[2][2] > ctr;
                            e.code[2] = win[2][1] > ctr;
                            e.code[1] = win[2][0] > ctr;
                            e.code[0] = win[1][0] > ctr;
                            e.brow    = BROW_W'((r - 3 - BORDER) / BLOCK_SIZE);
                            e.bcol    = BCOL_W'((c - 3 - BORDER) / BLOCK_SIZE);
                            e.is_last = (r + BORDER >= h + 1) && (c + BORDER >= w + 1);
                            code_expect_q.push_back(e);
                        end
                    end
                end
            end
        end
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_cnt = c + 1;
    endtask

    // ------------------------------------------------------------------
    // output side: back-pressure and checking
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_seen  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            hold_seen     <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen     <= hold_req;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall_en && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    code_word_t want, got;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.code    = m_axis_tdata[CODE_W-1:0];
            got.brow    = m_axis_tdata[CODE_W +: BROW_W];
            got.bcol    = m_axis_tdata[CODE_W + BROW_W +: BCOL_W];
            got.is_last = m_axis_tlast;
            codes_checked++;
            if (code_expect_q.size() == 0)
            begin
                $error("code word with none expected: code %0h row %0d col %0d",
                       got.code, got.brow, got.bcol);
                fail_count++;
            end
            else
            begin
                want = code_expect_q.pop_front();
                if (got.code !== want.code)
                begin
                    $error("code: expected %0h actual %0h", want.code, got.code);
                    fail_count++;
                end
                if (got.brow !== want.brow)
                begin
                    $error("block_row: expected %0d actual %0d", want.brow, got.brow);
                    fail_count++;
                end
                if (got.bcol !== want.bcol)
                begin
                    $error("block_col: expected %0d actual %0d", want.bcol, got.bcol);
                    fail_count++;
                end
                if (got.is_last !== want.is_last)
                begin
                    $error("frame_last: expected %0b actual %0b", want.is_last, got.is_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic logic [7:0] gen_pixel(input pix_kind_t kind);
        case (kind)
            PIX_NEAR:    return pix_base + 8'($urandom_range(0, 3));
            PIX_EXTREME: return ($urandom_range(0, 1) == 0) ? 8'h00 : PIX_MAX;
            PIX_BRIGHT:  return 8'($urandom_range(128, 255));
            PIX_FLAT:    return pix_base;
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        int unsigned gap;
        if (src_idle_en && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        do
            @(posedge clk);
        while (!s_axis_tready);
        lbp_predict(pix, fs);
        pixels_sent++;
    endtask

    // first word carries frame_start when asked; noisy runs drop stray ones in
    task automatic send_pixels(input int unsigned count, input pix_kind_t kind,
                               input bit with_start, input bit noisy);
        logic fs;
        pix_base = 8'($urandom_range(0, 252));
        for (int unsigned i = 0; i < count; i++)
        begin
            fs = (i == 0) ? with_start : (noisy && $urandom_range(0, 149) == 0);
            if (fs)
                frames_started++;
            send_pixel(gen_pixel(kind), fs);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_MODE:   mode_reg   = data[0];
            CFG_WIDTH:  width_reg  = data[IWID_W-1:0];
            CFG_HEIGHT: height_reg = data[HGT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input bit m, input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_MODE, {12'd0, m});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // wait out every pending word plus the pipeline tail
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (code_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // mode and height keep their reset values; a narrow frame keeps it short
        write_reg(CFG_WIDTH, 12);
        send_pixels(12 * 10, PIX_ANY, 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_small_frames();
        configure(1'b0, 9, 9);
        send_pixels(81, PIX_EXTREME, 1'b1, 1'b0);
        settle();
        configure(1'b1, 9, 9);
        send_pixels(81, PIX_ANY, 1'b1, 1'b0);
        settle();
        // below minimum clamps to 8 x 8, which yields no codes
        configure(1'b0, 3, 0);
        send_pixels(64, PIX_ANY, 1'b1, 1'b0);
        settle();
        // equal blocks never set a bit
        configure(1'b1, 10, 10);
        send_pixels(100, PIX_FLAT, 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_mode_switch_mid_frame();
        logic [11:0] junk;
        bit          m;
        m = 1'b0;
        configure(m, 12, 16);
        for (int row = 0; row < 16; row++)
        begin
            send_pixels(12, PIX_BRIGHT, row == 0, 1'b0);
            settle();
            m    = ~m;
            junk = 12'($urandom_range(0, 4095));
            write_reg(CFG_MODE, {junk, m});
            mode_switches++;
        end
        settle();
    endtask

    task automatic test_size_clamp();
        // height above range clamps to the maximum; a few rows are enough
        configure(1'b1, 9, 8191);
        send_pixels(9 * 12, PIX_ANY, 1'b1, 1'b0);
        settle();
        configure(1'b0, 0, 0);
        send_pixels(64, PIX_EXTREME, 1'b1, 1'b0);
        settle();
        // width above range clamps to the maximum, start of the first row only
        configure(1'b0, 2047, 9);
        send_pixels(48, PIX_NEAR, 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_counter_wrap();
        configure(1'b0, 9, 9);
        // two frames back to back with only the first marked, then a cut frame and a full one
        send_pixels(162, PIX_ANY, 1'b1, 1'b0);
        send_pixels(37, PIX_ANY, 1'b1, 1'b0);
        send_pixels(81, PIX_ANY, 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_output_hold();
        configure(1'b1, 16, 12);
        send_pixels(16 * 8, PIX_ANY, 1'b1, 1'b0);
        // hold the output over the rows that still produce codes
        hold_len = 300;
        hold_req++;
        send_pixels(16 * 4, PIX_ANY, 1'b0, 1'b0);
        settle();
    endtask

    task automatic test_random_frames();
        int unsigned       start_count, w, h, pick;
        logic [IWID_W-1:0] wv;
        logic [HGT_W-1:0]  hv;
        pix_kind_t         kind;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            wv   = (pick == 0) ? IWID_W'($urandom_range(0, 7)) :
                   (pick == 1) ? IWID_W'($urandom_range(17, 24)) :
                                 IWID_W'($urandom_range(8, 16));
            pick = $urandom_range(0, 9);
            hv   = (pick == 0) ? HGT_W'($urandom_range(0, 7)) :
                   (pick == 1) ? HGT_W'($urandom_range(15, 20)) :
                                 HGT_W'($urandom_range(8, 14));
            configure(1'($urandom_range(0, 1)), CFG_DATA_W'(wv), CFG_DATA_W'(hv));
            w    = eff_width();
            h    = eff_height();
            kind = pix_kind_t'($urandom_range(0, 4));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_pixels($urandom_range(1, w * h - 1), kind, 1'b1, 1'b0);
            else
                send_pixels(w * h, kind, 1'b1, pick == 1);
            settle();
        end
    endtask

    task automatic test_no_idle();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        configure(1'b0, 12, 12);
        send_pixels(12 * 12, PIX_ANY, 1'b1, 1'b0);
        settle();
        configure(1'b1, 12, 12);
        send_pixels(12 * 12, PIX_NEAR, 1'b1, 1'b0);
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_small_frames();
        test_mode_switch_mid_frame();
        test_size_clamp();
        test_counter_wrap();
        test_output_hold();
        test_random_frames();
        test_no_idle();
        $display("covered %0d pixels over %0d frame starts, %0d mid-frame mode switches",
                 pixels_sent, frames_started, mode_switches);
        $display("checked %0d code words incl. clamped sizes, wrap and output holds",
                 codes_checked);
        if (fail_count == 0 && code_expect_q.size() == 0)
            $display("block_lbp_code_extractor regression: pass");
        else
            $display("block_lbp_code_extractor regression: fail");
        $finish;
    end

    initial
    begin
        #80ms;
        $display("timeout waiting on the block");
        $display("block_lbp_code_extractor regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/lbp_pkg.sv
design/lbp_front.sv
design/lbp_line_store.sv
design/lbp_core.sv
design/block_lbp_code_extractor.sv
design/lbp_checker.sv
bench/block_lbp_code_extractor_tb.sv
